// ----- rtl/core/servo_pulse_slew_limiter_core_defines.svh -----
// ----------------------------------------------------------------------------
// Servo pulse slew limiter assertion macros
// Concurrent assertion helpers; they compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SERVO_PULSE_SLEW_LIMITER_CORE_DEFINES_SVH
`define SERVO_PULSE_SLEW_LIMITER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define SPSL_ASSERT(lbl, ck, rs, prop) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) \
    else $error("spsl assertion failed");
`define SPSL_ASSERT_NR(lbl, ck, prop) \
  lbl: assert property (@(posedge ck) prop) \
    else $error("spsl assertion failed");
`else
`define SPSL_ASSERT(lbl, ck, rs, prop)
`define SPSL_ASSERT_NR(lbl, ck, prop)
`endif
`endif

// ----- rtl/core/spsl_pkg.sv -----
// ----------------------------------------------------------------------------
// spsl_pkg
// Types and constants shared by the servo pulse slew limiter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package spsl_pkg;

  localparam logic [11:0] NEUTRAL_US    = 12'd1500;
  localparam logic [15:0] RAW_MIN_US    = 16'd1000;
  localparam logic [15:0] RAW_MAX_US    = 16'd2000;
  localparam logic [11:0] MIN_PULSE_RST = 12'd1000;
  localparam logic [11:0] MAX_PULSE_RST = 12'd2000;
  localparam logic [9:0]  STEP_RST      = 10'd10;

  localparam logic signed [15:0] PCT_FULL_Q8 = 16'sd25600;
  localparam logic signed [16:0] PCT_BIAS    = 17'sd25600;
  // 4096 * 51200, keeps the scaled product non-negative without changing parity
  localparam logic signed [30:0] MAP_OFFSET  = 31'sd209715200;
  // ceil(2^25 / 50), exact for quotients of 19-bit values
  localparam logic [19:0] RECIP_50    = 20'd671089;
  localparam int          RECIP_SHIFT = 25;
  localparam logic [5:0]  DIV_50      = 6'd50;
  localparam logic [5:0]  HALF_50     = 6'd25;

  localparam logic [3:0] STEER_CH    = 4'd0;
  localparam logic [3:0] THROTTLE_CH = 4'd1;

  localparam int OUT_DEPTH_DEF = 4;

  typedef enum logic [1:0] {
    CMD_TICK         = 2'd0,
    CMD_RAW          = 2'd1,
    CMD_STEER_PCT    = 2'd2,
    CMD_THROTTLE_PCT = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_MIN_PULSE  = 2'd0,
    REG_MAX_PULSE  = 2'd1,
    REG_STEER_STEP = 2'd2
  } reg_e;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [3:0]         channel;
    logic [15:0]        pulse_us;
    logic signed [15:0] percent_q8;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  out_channel;
    logic [11:0] out_pulse_us;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [11:0] min_pulse_us;
    logic [11:0] max_pulse_us;
    logic [9:0]  steer_step_us;
  } cfg_t;

  typedef struct packed {
    in_item_t    item;
    logic [13:0] q;
    logic [18:0] s;
    logic [9:0]  low10;
  } pipe_t;

  typedef struct packed {
    logic [1:0] count;
    out_item_t  first;
    out_item_t  second;
  } push_t;

endpackage

`default_nettype wire

// ----- rtl/core/servo_pulse_slew_limiter_core.sv -----
// ----------------------------------------------------------------------------
// servo_pulse_slew_limiter_core
// Servo command conditioner: percent map, raw pulse forcing, steering slew.
// ----------------------------------------------------------------------------
// Every item passes three register stages (input, map product, divide by 50
// through a reciprocal product) and is retired from the third, where the
// targets are updated and its results are written into a result queue of
// OUT_DEPTH entries. An item can be taken every cycle while the queue has
// room for two results; results leave one per cycle on the single result
// port while out_ready is high, so a stream of ticks (two results each) is
// held back by that port, while other commands can be taken one per cycle.
// Configuration writes are accepted every cycle and must only be issued while
// the block holds no item in flight. Reset is immediate; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module servo_pulse_slew_limiter_core #(
  parameter int OUT_DEPTH = spsl_pkg::OUT_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  spsl_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output spsl_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [11:0]         cfg_data
);
  import spsl_pkg::*;

  cfg_t    cfg;
  logic    c_valid;
  pipe_t   c_pipe;
  logic    room;
  logic    advance;
  logic    fire;
  push_t   push;

  assign cfg_ready = 1'b1;
  assign advance   = !c_valid || room;
  assign fire      = c_valid && room;
  assign in_ready  = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_pulse_us  <= MIN_PULSE_RST;
      cfg.max_pulse_us  <= MAX_PULSE_RST;
      cfg.steer_step_us <= STEP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MIN_PULSE:  cfg.min_pulse_us  <= cfg_data;
        REG_MAX_PULSE:  cfg.max_pulse_us  <= cfg_data;
        REG_STEER_STEP: cfg.steer_step_us <= cfg_data[9:0];
        default: begin
        end
      endcase
    end
  end

  spsl_front u_front (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .in_valid (in_valid),
    .in_item  (in_item),
    .cfg      (cfg),
    .c_valid  (c_valid),
    .c_pipe   (c_pipe)
  );

  spsl_exec u_exec (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .c_pipe (c_pipe),
    .cfg    (cfg),
    .push   (push)
  );

  spsl_out_fifo #(
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

// ----- rtl/core/spsl_front.sv -----
// ----------------------------------------------------------------------------
// spsl_front
// Input, product and reciprocal stages of the percent-to-pulse map.
// ----------------------------------------------------------------------------
`default_nettype none

module spsl_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic              in_valid,
  input  spsl_pkg::in_item_t in_item,
  input  spsl_pkg::cfg_t    cfg,
  output logic              c_valid,
  output spsl_pkg::pipe_t   c_pipe
);
  import spsl_pkg::*;

  logic               a_valid;
  in_item_t           a_item;
  logic               b_valid;
  in_item_t           b_item;
  logic [28:0]        b_m;

  logic signed [15:0] pct;
  logic signed [16:0] t_sum;
  logic [15:0]        span_t;
  logic signed [12:0] span_d;
  logic signed [29:0] prod;
  logic signed [30:0] m_sum;
  logic [18:0]        b_s;
  logic [38:0]        q_prod;

  always_comb begin
    pct = $signed(a_item.percent_q8);
    if (pct < -PCT_FULL_Q8) begin
      pct = -PCT_FULL_Q8;
    end else if (pct > PCT_FULL_Q8) begin
      pct = PCT_FULL_Q8;
    end
    t_sum  = 17'(pct) + PCT_BIAS;
    span_t = t_sum[15:0];
    span_d = $signed({1'b0, cfg.max_pulse_us}) - $signed({1'b0, cfg.min_pulse_us});
    prod   = span_d * $signed({1'b0, span_t});
    m_sum  = 31'(prod) + MAP_OFFSET;
  end

  assign b_s    = b_m[28:10];
  assign q_prod = {20'd0, b_s} * {19'd0, RECIP_50};

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else if (advance) begin
      a_valid <= in_valid;
      b_valid <= a_valid;
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_item       <= in_item;
      b_item       <= a_item;
      b_m          <= m_sum[28:0];
      c_pipe.item  <= b_item;
      c_pipe.q     <= q_prod[RECIP_SHIFT +: 14];
      c_pipe.s     <= b_s;
      c_pipe.low10 <= b_m[9:0];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/spsl_exec.sv -----
// ----------------------------------------------------------------------------
// spsl_exec
// Final stage: rounding, steering slew, raw pulse forcing and target state.
// ----------------------------------------------------------------------------
`default_nettype none

module spsl_exec (
  input  logic            clk,
  input  logic            rst,
  input  logic            fire,
  input  spsl_pkg::pipe_t c_pipe,
  input  spsl_pkg::cfg_t  cfg,
  output spsl_pkg::push_t push
);
  import spsl_pkg::*;

  logic [11:0]        steer_target;
  logic [11:0]        steer_target_next;
  logic [11:0]        steer_last;
  logic [11:0]        steer_last_next;
  logic [11:0]        throttle_target;
  logic [11:0]        throttle_target_next;

  logic [19:0]        q_x50;
  logic signed [20:0] rem_s;
  logic signed [20:0] rem_w;
  logic [13:0]        q_c;
  logic [5:0]         rem;
  logic               round_up;
  logic [11:0]        pct_pulse;

  logic signed [12:0] diff;
  logic signed [12:0] step13;
  logic [11:0]        steer_val;
  logic [15:0]        raw_pw;
  logic [11:0]        raw_pulse;

  // quotient correction and round half to even
  always_comb begin
    q_x50 = {6'd0, c_pipe.q} * {14'd0, DIV_50};
    rem_s = $signed({2'b00, c_pipe.s}) - $signed({1'b0, q_x50});
    q_c   = c_pipe.q;
    rem_w = rem_s;
    if (rem_s < 21'sd0) begin
      q_c   = c_pipe.q - 14'd1;
      rem_w = rem_s + $signed({15'd0, DIV_50});
    end else if (rem_s >= $signed({15'd0, DIV_50})) begin
      q_c   = c_pipe.q + 14'd1;
      rem_w = rem_s - $signed({15'd0, DIV_50});
    end
    rem      = rem_w[5:0];
    round_up = (rem > HALF_50) ||
               ((rem == HALF_50) && ((c_pipe.low10 != 10'd0) || q_c[0]));
    pct_pulse = cfg.min_pulse_us + q_c[11:0] + {11'd0, round_up};
  end

  always_comb begin
    diff   = $signed({1'b0, steer_target}) - $signed({1'b0, steer_last});
    step13 = $signed({3'b000, cfg.steer_step_us});
    if (diff > step13) begin
      steer_val = steer_last + {2'b00, cfg.steer_step_us};
    end else if (-diff > step13) begin
      steer_val = steer_last - {2'b00, cfg.steer_step_us};
    end else begin
      steer_val = steer_target;
    end
  end

  always_comb begin
    raw_pw = c_pipe.item.pulse_us;
    if (raw_pw != 16'd0) begin
      if (raw_pw < RAW_MIN_US) begin
        raw_pw = RAW_MIN_US;
      end else if (raw_pw > RAW_MAX_US) begin
        raw_pw = RAW_MAX_US;
      end
    end
    raw_pulse = raw_pw[11:0];
  end

  always_comb begin
    steer_target_next    = steer_target;
    steer_last_next      = steer_last;
    throttle_target_next = throttle_target;
    push                 = '0;
    if (fire) begin
      case (c_pipe.item.cmd)
        CMD_TICK: begin
          steer_last_next          = steer_val;
          push.count               = 2'd2;
          push.first.out_channel   = STEER_CH;
          push.first.out_pulse_us  = steer_val;
          push.first.last          = 1'b0;
          push.second.out_channel  = THROTTLE_CH;
          push.second.out_pulse_us = throttle_target;
          push.second.last         = 1'b1;
        end
        CMD_RAW: begin
          if (c_pipe.item.channel == STEER_CH) begin
            steer_target_next = raw_pulse;
            steer_last_next   = raw_pulse;
          end else if (c_pipe.item.channel == THROTTLE_CH) begin
            throttle_target_next = raw_pulse;
          end
          push.count              = 2'd1;
          push.first.out_channel  = c_pipe.item.channel;
          push.first.out_pulse_us = raw_pulse;
          push.first.last         = 1'b1;
        end
        CMD_STEER_PCT: begin
          steer_target_next = pct_pulse;
        end
        CMD_THROTTLE_PCT: begin
          throttle_target_next = pct_pulse;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steer_target    <= NEUTRAL_US;
      steer_last      <= NEUTRAL_US;
      throttle_target <= NEUTRAL_US;
    end else begin
      steer_target    <= steer_target_next;
      steer_last      <= steer_last_next;
      throttle_target <= throttle_target_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/spsl_out_fifo.sv -----
// ----------------------------------------------------------------------------
// spsl_out_fifo
// Result queue; takes up to two items per cycle, hands out one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none
`include "servo_pulse_slew_limiter_core_defines.svh"

module spsl_out_fifo #(
  parameter int DEPTH = spsl_pkg::OUT_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  spsl_pkg::push_t     push,
  output logic                room,
  output logic                out_valid,
  input  logic                out_ready,
  output spsl_pkg::out_item_t out_item
);
  import spsl_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  out_item_t       mem [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   wr_ptr1;
  logic [PW-1:0]   wr_ptr2;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic [CW-1:0]   count_next;
  logic            pop;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign wr_ptr1    = ptr_inc(wr_ptr);
  assign wr_ptr2    = ptr_inc(wr_ptr1);
  assign out_valid  = (count != '0);
  assign out_item   = mem[rd_ptr];
  assign pop        = out_valid && out_ready;
  assign room       = (count <= CW'(DEPTH - 2));
  assign count_next = count + CW'(push.count) - CW'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push.count == 2'd1) begin
        wr_ptr <= wr_ptr1;
      end else if (push.count == 2'd2) begin
        wr_ptr <= wr_ptr2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr1] <= push.second;
    end
  end

  `SPSL_ASSERT(a_count_bound, clk, rst, count <= CW'(DEPTH))
  `SPSL_ASSERT(a_no_overflow, clk, rst, (push.count == 2'd0) || room)
  `SPSL_ASSERT(a_idle_stays_empty, clk, rst, ((count == '0) && (push.count == 2'd0)) |=> !out_valid)
  `SPSL_ASSERT_NR(a_empty_after_reset, clk, rst |=> ((count == '0) && !out_valid))

endmodule

`default_nettype wire

// ----- tb/tb_servo_pulse_slew_limiter_core.sv -----
// ----------------------------------------------------------------------------
// tb_servo_pulse_slew_limiter_core
// Self-checking bench for the servo slew limiter. A queue-fed driver sends
// directed and random command items in bursts. A monitor predicts every pulse
// write from its own copy of the targets and registers, and checks the writes
// in order while the receiver stalls on its own pattern and holds off once
// for a long stretch. Registers are rewritten between phases (default,
// reversed range with zero step, full range, random).
// ----------------------------------------------------------------------------
`default_nettype none

module tb_servo_pulse_slew_limiter_core;
  import spsl_pkg::*;

  localparam int     STALL_LIMIT = 4000;
  localparam longint MAP_DEN     = 51200;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [11:0] cfg_data;

  in_item_t  cmd_queue[$];
  out_item_t pulse_writes_due[$];

  // predicted block state
  logic [11:0] cfg_min, cfg_max, steer_tgt, steer_now, thr_tgt;
  logic [9:0]  cfg_step;

  int   cmds_queued = 0;
  int   cmds_taken = 0;
  int   writes_seen = 0;
  int   cfg_writes = 0;
  int   bad = 0;
  int   idle_cycles = 0;
  int   cmd_count[4] = '{0, 0, 0, 0};
  logic in_fire_q = 1'b0;

  int   gap_left = 0;
  int   burst_left = 0;
  int   mode_left = 0;
  int   stall_mode = 0;
  int   hold_left = 0;
  logic hold_done = 1'b0;
  logic [7:0] stall_mask = 8'hff;

  always #10 clk = ~clk;

  servo_pulse_slew_limiter_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  function automatic logic [11:0] percent_to_pulse(logic signed [15:0] pct);
    longint p, lo, hi, num, q, r;
    p  = pct;
    lo = longint'(cfg_min);
    hi = longint'(cfg_max);
    if (p < -longint'(PCT_FULL_Q8)) p = -longint'(PCT_FULL_Q8);
    if (p > longint'(PCT_FULL_Q8)) p = longint'(PCT_FULL_Q8);
    num = (hi - lo) * (p + longint'(PCT_FULL_Q8));
    q = num / MAP_DEN;
    r = num % MAP_DEN;
    if (r < 0) begin
      r += MAP_DEN;
      q -= 1;
    end
    // round to nearest, ties to even
    if (2 * r > MAP_DEN || (2 * r == MAP_DEN && q[0])) q += 1;
    num = lo + q;
    return num[11:0];
  endfunction

  function automatic out_item_t pulse_write(logic [3:0] ch, logic [11:0] pw, logic fin);
    out_item_t w;
    w.out_channel  = ch;
    w.out_pulse_us = pw;
    w.last         = fin;
    return w;
  endfunction

  task automatic apply_command(in_item_t c);
    int d, v, st;
    logic [15:0] pw;
    case (cmd_e'(c.cmd))
      CMD_TICK: begin
        st = int'(cfg_step);
        d  = int'(steer_tgt) - int'(steer_now);
        v  = int'(steer_tgt);
        if (d > st) v = int'(steer_now) + st;
        else if (-d > st) v = int'(steer_now) - st;
        steer_now = v[11:0];
        pulse_writes_due.push_back(pulse_write(STEER_CH, steer_now, 1'b0));
        pulse_writes_due.push_back(pulse_write(THROTTLE_CH, thr_tgt, 1'b1));
      end
      CMD_RAW: begin
        pw = c.pulse_us;
        if (pw != 16'd0) begin
          if (pw < RAW_MIN_US) pw = RAW_MIN_US;
          if (pw > RAW_MAX_US) pw = RAW_MAX_US;
        end
        if (c.channel == STEER_CH) begin
          steer_now = pw[11:0];
          steer_tgt = pw[11:0];
        end else if (c.channel == THROTTLE_CH) begin
          thr_tgt = pw[11:0];
        end
        pulse_writes_due.push_back(pulse_write(c.channel, pw[11:0], 1'b1));
      end
      CMD_STEER_PCT: steer_tgt = percent_to_pulse(c.percent_q8);
      default:       thr_tgt = percent_to_pulse(c.percent_q8);
    endcase
  endtask

  // monitor: register writes, accepted commands, checked pulse writes, watchdog
  always @(posedge clk) begin
    out_item_t due;
    in_fire_q = in_valid && in_ready;
    if (rst) begin
      cfg_min   = MIN_PULSE_RST;
      cfg_max   = MAX_PULSE_RST;
      cfg_step  = STEP_RST;
      steer_tgt = NEUTRAL_US;
      steer_now = NEUTRAL_US;
      thr_tgt   = NEUTRAL_US;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (reg_e'(cfg_index))
          REG_MIN_PULSE:  cfg_min = cfg_data;
          REG_MAX_PULSE:  cfg_max = cfg_data;
          REG_STEER_STEP: cfg_step = cfg_data[9:0];
          default: ;
        endcase
        cfg_writes++;
      end
      if (in_fire_q) begin
        apply_command(in_item);
        cmd_count[in_item.cmd]++;
        cmds_taken++;
      end
      if (out_valid && out_ready) begin
        writes_seen++;
        if (pulse_writes_due.size() == 0) begin
          bad++;
          if (bad <= 10)
            $display("unexpected write: ch %0d pw %0d last %0d",
                     out_item.out_channel, out_item.out_pulse_us, out_item.last);
        end else begin
          due = pulse_writes_due.pop_front();
          if (out_item.out_channel !== due.out_channel ||
              out_item.out_pulse_us !== due.out_pulse_us ||
              out_item.last !== due.last) begin
            bad++;
            if (bad <= 10)
              $display("mismatch: expected ch %0d pw %0d last %0d, got ch %0d pw %0d last %0d",
                       due.out_channel, due.out_pulse_us, due.last,
                       out_item.out_channel, out_item.out_pulse_us, out_item.last);
          end
        end
      end
      if (in_fire_q || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
        $display("tb_servo_pulse_slew_limiter_core: done, errors");
        $finish;
      end
    end
  end

  // sender: bursts of items with random gaps
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire_q) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (cmd_queue.size() > 0) begin
        in_item  <= cmd_queue.pop_front();
        in_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern is redrawn when its mode counter runs out, one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!hold_done && writes_seen >= 100 && cmd_queue.size() >= 30) begin
      hold_done = 1'b1;
      hold_left = 250;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        mode_left  = 64;
        stall_mode = $urandom_range(0, 3);
        stall_mask = 8'($urandom);
      end
      mode_left--;
      case (stall_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        2:       out_ready <= ($urandom_range(0, 3) == 0);
        default: begin
          out_ready <= stall_mask[0];
          stall_mask = {stall_mask[0], stall_mask[7:1]};
        end
      endcase
    end
  end

  task automatic queue_cmd(cmd_e c, logic [3:0] ch, logic [15:0] pw,
                           logic signed [15:0] pct);
    in_item_t it;
    it.cmd        = c;
    it.channel    = ch;
    it.pulse_us   = pw;
    it.percent_q8 = pct;
    cmd_queue.push_back(it);
    cmds_queued++;
  endtask

  task automatic queue_ticks(int n);
    repeat (n) queue_cmd(CMD_TICK, 4'($urandom), 16'($urandom), 16'($urandom));
  endtask

  function automatic logic signed [15:0] random_percent();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'($urandom);
    if (r == 1) return ($urandom_range(0, 1) == 1) ? PCT_FULL_Q8 : -PCT_FULL_Q8;
    return 16'($urandom_range(0, 51200) - 25600);
  endfunction

  function automatic logic [15:0] random_pulse();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'd0;
    if (r <= 2) return 16'($urandom);
    return 16'($urandom_range(900, 2100));
  endfunction

  function automatic logic [3:0] random_channel();
    return ($urandom_range(0, 4) < 3) ? 4'($urandom_range(0, 1)) : 4'($urandom);
  endfunction

  task automatic queue_random(int n);
    int made, r, k;
    made = 0;
    while (made < n) begin
      r = $urandom_range(0, 9);
      if (r < 6) begin
        // new target, then let steering slew toward it
        k = $urandom_range(1, 10);
        queue_cmd(($urandom_range(0, 9) < 7) ? CMD_STEER_PCT : CMD_THROTTLE_PCT,
                  4'($urandom), 16'($urandom), random_percent());
        queue_ticks(k);
        made += k + 1;
      end else if (r < 8) begin
        k = $urandom_range(0, 3);
        queue_cmd(CMD_RAW, random_channel(), random_pulse(), 16'($urandom));
        queue_ticks(k);
        made += k + 1;
      end else begin
        queue_cmd(cmd_e'(2'($urandom)), 4'($urandom), 16'($urandom), 16'($urandom));
        made++;
      end
    end
  endtask

  task automatic write_reg(reg_e idx, logic [11:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
  endtask

  task automatic set_config(logic [11:0] lo, logic [11:0] hi, logic [11:0] step);
    write_reg(REG_MIN_PULSE, lo);
    write_reg(REG_MAX_PULSE, hi);
    write_reg(REG_STEER_STEP, step);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // wait for every item taken and every write seen, then let percent items retire
  task automatic settle();
    do @(negedge clk);
    while (cmds_taken != cmds_queued || pulse_writes_due.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  initial begin
    int step;
    rst       = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = REG_MIN_PULSE;
    cfg_data  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: raw forcing, clamps, rounding ties, slewing
    queue_cmd(CMD_TICK, 4'd0, 16'd0, 16'sd0);
    queue_cmd(CMD_RAW, STEER_CH, 16'd0, 16'sd0);
    queue_cmd(CMD_TICK, 4'hf, 16'hffff, 16'sh7fff);
    queue_cmd(CMD_RAW, STEER_CH, 16'hffff, 16'sd0);
    queue_cmd(CMD_RAW, THROTTLE_CH, 16'd999, 16'sd0);
    queue_cmd(CMD_RAW, 4'hf, 16'd2001, 16'sd0);
    queue_cmd(CMD_RAW, 4'd7, 16'd1000, 16'sd0);
    queue_cmd(CMD_STEER_PCT, 4'd0, 16'd0, 16'sh8000);
    queue_cmd(CMD_TICK, 4'd0, 16'd0, 16'sd0);
    queue_cmd(CMD_THROTTLE_PCT, 4'd0, 16'd0, 16'sh7fff);
    queue_cmd(CMD_TICK, 4'd0, 16'd0, 16'sd0);
    queue_cmd(CMD_STEER_PCT, 4'd0, 16'd0, -16'sd25472);    // tie, stays even
    queue_cmd(CMD_THROTTLE_PCT, 4'd0, 16'd0, -16'sd25216); // tie, rounds up
    queue_cmd(CMD_TICK, 4'd0, 16'd0, 16'sd0);
    queue_cmd(CMD_RAW, THROTTLE_CH, 16'd0, 16'sd0);
    queue_cmd(CMD_TICK, 4'd0, 16'd0, 16'sd0);
    queue_cmd(CMD_STEER_PCT, 4'd0, 16'd0, 16'sd0);
    settle();

    // reversed range, zero step
    set_config(12'd2500, 12'd500, 12'd0);
    queue_cmd(CMD_STEER_PCT, 4'd0, 16'd0, PCT_FULL_Q8);
    queue_cmd(CMD_TICK, 4'd0, 16'd0, 16'sd0);
    queue_cmd(CMD_THROTTLE_PCT, 4'd0, 16'd0, 16'sh8000);
    queue_cmd(CMD_TICK, 4'd0, 16'd0, 16'sd0);
    queue_cmd(CMD_RAW, STEER_CH, 16'd1700, 16'sd0);
    queue_cmd(CMD_STEER_PCT, 4'd0, 16'd0, -16'sd5120);     // maps to 1700
    queue_cmd(CMD_TICK, 4'd0, 16'd0, 16'sd0);
    settle();

    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 0) begin
        set_config(12'd0, 12'd4095, 12'hfff);
      end else if (ph == 1) begin
        set_config(12'd4095, 12'd0, 12'd1);
      end else begin
        case ($urandom_range(0, 3))
          0:       step = 0;
          1:       step = $urandom_range(200, 1023);
          default: step = $urandom_range(1, 40);
        endcase
        set_config(12'($urandom), 12'($urandom), {2'($urandom), 10'(step)});
      end
      queue_random(80);
      settle();
    end

    $display("summary: %0d commands (%0d ticks, %0d raw, %0d steer pct, %0d throttle pct)",
             cmds_taken, cmd_count[CMD_TICK], cmd_count[CMD_RAW],
             cmd_count[CMD_STEER_PCT], cmd_count[CMD_THROTTLE_PCT]);
    $display("summary: %0d pulse writes checked, %0d register writes, %0d mismatches",
             writes_seen, cfg_writes, bad);
    if (bad == 0) begin
      $display("tb_servo_pulse_slew_limiter_core: done, clean");
    end else begin
      $display("tb_servo_pulse_slew_limiter_core: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+rtl/core
rtl/core/spsl_pkg.sv
rtl/core/spsl_front.sv
rtl/core/spsl_exec.sv
rtl/core/spsl_out_fifo.sv
rtl/core/servo_pulse_slew_limiter_core.sv
tb/tb_servo_pulse_slew_limiter_core.sv
